### sv/pps_pkg.sv
// shared types, constants and arithmetic helpers of the position smoother
package pps_pkg;

  localparam int unsigned POS_W   = 32;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned DAMP_W  = 17;
  localparam int unsigned SLOT_W  = 3;
  localparam int unsigned AXES    = 3;
  // dividend of the velocity divide: 33-bit magnitude shifted up by 16
  localparam int unsigned NUM_W   = 49;
  localparam int unsigned CNT_W   = 6;
  localparam int unsigned WIDE_W  = 66;

  localparam logic [DAMP_W-1:0] DAMP_ONE = 17'h10000;

  // status codes of a result word
  localparam logic [1:0] STAT_SMOOTH = 2'd0;
  localparam logic [1:0] STAT_FIRST  = 2'd1;
  localparam logic [1:0] STAT_HELD   = 2'd2;

  // register index of the damping factor
  localparam logic REG_DAMPING = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DECIDE,
    ST_LANES,
    ST_OUT
  } ctl_state_t;

  typedef enum logic [2:0] {
    LN_IDLE,
    LN_MUL1,
    LN_ANCHOR,
    LN_MUL2,
    LN_OUT,
    LN_DIV_START,
    LN_DIV_WAIT
  } lane_state_t;

  // per-slot history held in memory
  typedef struct packed {
    logic signed [POS_W-1:0] last_x;
    logic signed [POS_W-1:0] last_y;
    logic signed [POS_W-1:0] last_z;
    logic signed [POS_W-1:0] vel_x;
    logic signed [POS_W-1:0] vel_y;
    logic signed [POS_W-1:0] vel_z;
    logic [TIME_W-1:0]       last_time;
  } slot_rec_t;

  // handshake between control and one axis lane
  typedef struct packed {
    logic start;
  } lane_ctl_t;

  typedef struct packed {
    logic done;
  } lane_sts_t;

  // saturate a wide signed value to the 32-bit signed range
  function automatic logic signed [POS_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] max_v;
    logic signed [WIDE_W-1:0] min_v;
    max_v = WIDE_W'(64'sh7FFF_FFFF);
    min_v = -WIDE_W'(64'sh8000_0000);
    if (v > max_v) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < min_v) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[POS_W-1:0];
    end
  endfunction

endpackage

### sv/predictive_position_smoother.sv
// Position smoother top level: a smoothed word passes through acceptance, history read,
// decision, four multiply and blend stages per axis, divider start, a bit-serial divide per
// axis for the new velocity, write-back and output load, the three axis lanes running side by
// side. A first sample, a held sample or an out-of-range slot skips the lanes and goes from
// decision straight to output load. The next item is accepted once the previous one has
// reached the output register, so a result waiting there does not block the input. Slot
// history lives in a memory with a registered read; the per-slot valid flags are
// flip-flops cleared by reset, so no clearing pass is needed.
module predictive_position_smoother
  import pps_pkg::*;
#(
  parameter int SLOTS = 8
)
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [SLOT_W-1:0]        slot,
  input  logic [TIME_W-1:0]        stamp,
  input  logic signed [POS_W-1:0]  pos_x,
  input  logic signed [POS_W-1:0]  pos_y,
  input  logic signed [POS_W-1:0]  pos_z,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [POS_W-1:0]  out_x,
  output logic signed [POS_W-1:0]  out_y,
  output logic signed [POS_W-1:0]  out_z,
  output logic [1:0]               status
);

  localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  ctl_state_t state, state_next;

  logic [DAMP_W-1:0]       damping;
  logic [SLOTS-1:0]        slot_valid;
  slot_rec_t               mem [SLOTS];
  slot_rec_t               rd_rec;
  slot_rec_t               wr_rec;
  logic                    mem_we;

  logic [SLOT_W-1:0]       slot_r;
  logic [TIME_W-1:0]       time_r;
  logic signed [POS_W-1:0] px_r, py_r, pz_r;
  logic [ADDR_W-1:0]       idx;
  logic                    in_range;

  logic signed [POS_W-1:0] res_x, res_y, res_z;
  logic [1:0]              res_stat;

  logic                    case_first, case_held, case_smooth;
  logic                    lane_go;
  lane_ctl_t               lane_ctl;
  lane_sts_t               lane_sts [AXES];
  logic                    lanes_done;
  logic signed [POS_W-1:0] lane_in   [AXES];
  logic signed [POS_W-1:0] lane_last [AXES];
  logic signed [POS_W-1:0] lane_vel  [AXES];
  logic signed [POS_W-1:0] lane_pos  [AXES];
  logic signed [POS_W-1:0] lane_nvel [AXES];
  logic [TIME_W-1:0]       dt;
  logic                    out_free;
  logic                    load_out;

  // register port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      damping <= '0;
    end else if (psel && penable && pwrite && (paddr[2] == REG_DAMPING)) begin
      damping <= pwdata[DAMP_W-1:0];
    end
  end
  assign prdata = (paddr[2] == REG_DAMPING) ? 32'(damping) : 32'd0;

  // item capture and history read
  assign idx      = ADDR_W'(slot_r);
  assign in_range = (32'(slot_r) < 32'(SLOTS));
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      slot_r <= slot;
      time_r <= stamp;
      px_r   <= pos_x;
      py_r   <= pos_y;
      pz_r   <= pos_z;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      rd_rec <= mem[idx];
    end
    if (mem_we) begin
      mem[idx] <= wr_rec;
    end
  end

  // classify the word
  always_comb begin
    case_first  = in_range && !slot_valid[idx];
    case_held   = in_range && slot_valid[idx] && (time_r <= rd_rec.last_time);
    case_smooth = in_range && slot_valid[idx] && (time_r > rd_rec.last_time);
    dt          = time_r - rd_rec.last_time;
  end

  // lane operands
  always_comb begin
    lane_in[0]   = px_r;
    lane_in[1]   = py_r;
    lane_in[2]   = pz_r;
    lane_last[0] = rd_rec.last_x;
    lane_last[1] = rd_rec.last_y;
    lane_last[2] = rd_rec.last_z;
    lane_vel[0]  = rd_rec.vel_x;
    lane_vel[1]  = rd_rec.vel_y;
    lane_vel[2]  = rd_rec.vel_z;
  end

  // three axis lanes in parallel
  assign lane_ctl.start = lane_go;
  for (genvar g = 0; g < AXES; g++) begin : g_lane
    pps_axis u_axis (
      .clk      (clk),
      .rst      (rst),
      .ctl      (lane_ctl),
      .in_pos   (lane_in[g]),
      .last_pos (lane_last[g]),
      .last_vel (lane_vel[g]),
      .dt       (dt),
      .damp     (damping),
      .sts      (lane_sts[g]),
      .new_pos  (lane_pos[g]),
      .new_vel  (lane_nvel[g])
    );
  end
  assign lanes_done = lane_sts[0].done && lane_sts[1].done && lane_sts[2].done;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_READ;
      ST_READ:   state_next = ST_DECIDE;
      ST_DECIDE: state_next = case_smooth ? ST_LANES : ST_OUT;
      ST_LANES:  if (lanes_done) state_next = ST_OUT;
      ST_OUT:    if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control outputs
  always_comb begin
    in_ready = (state == ST_IDLE);
    lane_go  = (state == ST_DECIDE) && case_smooth;
    out_free = !out_valid || out_ready;
    load_out = (state == ST_OUT) && out_free;
    mem_we   = ((state == ST_DECIDE) && case_first) || ((state == ST_LANES) && lanes_done);
    if (state == ST_LANES) begin
      wr_rec = '{last_x: lane_pos[0], last_y: lane_pos[1], last_z: lane_pos[2],
                 vel_x: lane_nvel[0], vel_y: lane_nvel[1], vel_z: lane_nvel[2],
                 last_time: time_r};
    end else begin
      wr_rec = '{last_x: px_r, last_y: py_r, last_z: pz_r,
                 vel_x: '0, vel_y: '0, vel_z: '0, last_time: time_r};
    end
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if ((state == ST_DECIDE) && case_first) begin
      slot_valid[idx] <= 1'b1;
    end
  end

  // merge lane results, or the held or first-sample position, into the result word
  always_ff @(posedge clk) begin
    if (state == ST_DECIDE) begin
      if (case_held) begin
        res_x    <= rd_rec.last_x;
        res_y    <= rd_rec.last_y;
        res_z    <= rd_rec.last_z;
        res_stat <= STAT_HELD;
      end else begin
        res_x    <= px_r;
        res_y    <= py_r;
        res_z    <= pz_r;
        res_stat <= STAT_FIRST;
      end
    end else if ((state == ST_LANES) && lanes_done) begin
      res_x    <= lane_pos[0];
      res_y    <= lane_pos[1];
      res_z    <= lane_pos[2];
      res_stat <= STAT_SMOOTH;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_x  <= res_x;
      out_y  <= res_y;
      out_z  <= res_z;
      status <= res_stat;
    end
  end

  // lanes finish only while control waits for them
  a_lane_done_state: assert property (@(posedge clk) disable iff (rst)
    lanes_done |-> (state == ST_LANES))
    else $error("lanes finished outside of lane wait");

  // an accepted word always goes to the history read next
  a_accept_read: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_READ))
    else $error("accepted word did not start a history read");

  // a blocked result keeps control in the output state
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_OUT) && out_valid && !out_ready) |=> (state == ST_OUT))
    else $error("result dropped while output was stalled");

endmodule

### sv/pps_divider.sv
// restoring unsigned divider, one quotient bit per cycle
module pps_divider
  import pps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  dividend,
  input  logic [TIME_W-1:0] divisor,
  output logic              done,
  output logic [NUM_W-1:0]  quotient
);

  logic [NUM_W-1:0]  dq;
  logic [TIME_W-1:0] rem;
  logic [TIME_W-1:0] dsr;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [TIME_W:0]   rem_sh;
  logic [TIME_W:0]   rem_sub;
  logic              fits;

  // trial subtract of the shifted remainder
  always_comb begin
    rem_sh  = {rem, dq[NUM_W-1]};
    rem_sub = rem_sh - {1'b0, dsr};
    fits    = (rem_sh >= {1'b0, dsr});
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      dq  <= {dq[NUM_W-2:0], fits};
      rem <= fits ? rem_sub[TIME_W-1:0] : rem_sh[TIME_W-1:0];
    end
  end

  assign quotient = dq;

endmodule

### sv/pps_axis.sv
// one axis lane: extrapolate, blend, and new velocity through a serial divide
module pps_axis
  import pps_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  lane_ctl_t               ctl,
  input  logic signed [POS_W-1:0] in_pos,
  input  logic signed [POS_W-1:0] last_pos,
  input  logic signed [POS_W-1:0] last_vel,
  input  logic [TIME_W-1:0]       dt,
  input  logic [DAMP_W-1:0]       damp,
  output lane_sts_t               sts,
  output logic signed [POS_W-1:0] new_pos,
  output logic signed [POS_W-1:0] new_vel
);

  lane_state_t state, state_next;

  logic signed [POS_W-1:0] in_r;
  logic signed [POS_W-1:0] last_r;
  logic signed [POS_W-1:0] vel_r;
  logic [TIME_W-1:0]       dt_r;
  logic [DAMP_W-1:0]       a_r;
  logic signed [64:0]      prod1;
  logic signed [POS_W-1:0] anchor;
  logic signed [50:0]      prod2;
  logic signed [POS_W:0]   step;
  logic                    step_neg;
  logic [POS_W:0]          step_mag;
  logic                    div_start;
  logic                    div_done;
  logic [NUM_W-1:0]        quo;
  logic signed [WIDE_W-1:0] vel_wide;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      LN_IDLE:      if (ctl.start) state_next = LN_MUL1;
      LN_MUL1:      state_next = LN_ANCHOR;
      LN_ANCHOR:    state_next = LN_MUL2;
      LN_MUL2:      state_next = LN_OUT;
      LN_OUT:       state_next = LN_DIV_START;
      LN_DIV_START: state_next = LN_DIV_WAIT;
      LN_DIV_WAIT:  if (div_done) state_next = LN_IDLE;
      default:      state_next = LN_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LN_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // outputs of the sequencer
  always_comb begin
    div_start = (state == LN_DIV_START);
    sts.done  = (state == LN_DIV_WAIT) && div_done;
  end

  // step magnitude for the velocity divide
  always_comb begin
    step     = (POS_W+1)'(new_pos) - (POS_W+1)'(last_r);
    step_neg = step[POS_W];
    step_mag = step_neg ? (POS_W+1)'(-step) : step;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      LN_IDLE: begin
        if (ctl.start) begin
          in_r   <= in_pos;
          last_r <= last_pos;
          vel_r  <= last_vel;
          dt_r   <= dt;
          a_r    <= damp[DAMP_W-1] ? DAMP_ONE : damp;
        end
      end
      LN_MUL1: prod1 <= vel_r * $signed({1'b0, dt_r});
      LN_ANCHOR: anchor <= sat32(WIDE_W'(last_r) + WIDE_W'(prod1 >>> 16));
      LN_MUL2: prod2 <= ((POS_W+1)'(anchor) - (POS_W+1)'(in_r)) * $signed({1'b0, a_r});
      LN_OUT: new_pos <= sat32(WIDE_W'(in_r) + WIDE_W'(prod2 >>> 16));
      LN_DIV_START: begin
      end
      LN_DIV_WAIT: begin
      end
      default: begin
      end
    endcase
  end

  // signed quotient from the magnitude result
  always_comb begin
    vel_wide = $signed(WIDE_W'(quo));
    if (step_neg) begin
      vel_wide = -vel_wide;
    end
  end

  // new velocity is valid in the cycle the divide reports done
  assign new_vel = sat32(vel_wide);

  pps_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({step_mag, 16'b0}),
    .divisor  (dt_r),
    .done     (div_done),
    .quotient (quo)
  );

endmodule

### sim/tb.sv
// self-checking testbench of the predictive position smoother
module tb;
  import pps_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOTS = 8;
  localparam int N_RAND = 1700;
  localparam int WD_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0, in_ready;
  logic [SLOT_W-1:0] slot = '0;
  logic [TIME_W-1:0] stamp = '0;
  logic signed [POS_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic out_valid, out_ready = 1'b0;
  logic signed [POS_W-1:0] out_x, out_y, out_z;
  logic [1:0] status;

  predictive_position_smoother #(.SLOTS(NSLOTS)) u_dut (.*);

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct packed {
    logic signed [31:0] x, y, z;
    logic [1:0] st;
  } smooth_word_t;

  // predictor copy of slot history and damping
  logic [16:0] damping;
  logic hist_valid [NSLOTS];
  longint hist_pos [NSLOTS][3];
  longint hist_vel [NSLOTS][3];
  logic [31:0] hist_time [NSLOTS];

  smooth_word_t expected_q[$];
  int mismatches = 0;
  int idle_cnt = 0;
  bit stim_done = 0;
  bit no_idle = 0;
  int hold_off = 0;
  logic [16:0] damp_set [5] = '{17'd0, 17'h10000, 17'h1FFFF, 17'd32768, 17'd1};

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint floor16(longint p);
    return p >>> 16;
  endfunction

  function automatic smooth_word_t predict_smooth(logic [2:0] s, logic [31:0] t,
                                                  logic signed [31:0] px,
                                                  logic signed [31:0] py,
                                                  logic signed [31:0] pz);
    smooth_word_t w;
    longint inp [3];
    longint res [3];
    longint dt, a, anchor, o;
    inp[0] = px; inp[1] = py; inp[2] = pz;
    res = inp;
    w.st = STAT_FIRST;
    if (s < NSLOTS) begin
      if (!hist_valid[s]) begin
        for (int i = 0; i < 3; i++) begin
          hist_pos[s][i] = inp[i];
          hist_vel[s][i] = 0;
        end
        hist_time[s] = t;
        hist_valid[s] = 1'b1;
      end else if (t <= hist_time[s]) begin
        for (int i = 0; i < 3; i++) res[i] = hist_pos[s][i];
        w.st = STAT_HELD;
      end else begin
        dt = longint'(t - hist_time[s]);
        a = (damping > DAMP_ONE) ? 65536 : longint'(damping);
        for (int i = 0; i < 3; i++) begin
          anchor = clamp32(hist_pos[s][i] + floor16(hist_vel[s][i] * dt));
          o = clamp32(inp[i] + floor16(a * (anchor - inp[i])));
          hist_vel[s][i] = clamp32(((o - hist_pos[s][i]) * 65536) / dt);
          hist_pos[s][i] = o;
          res[i] = o;
        end
        hist_time[s] = t;
        w.st = STAT_SMOOTH;
      end
    end
    w.x = res[0][31:0]; w.y = res[1][31:0]; w.z = res[2][31:0];
    return w;
  endfunction

  // register write, setup then access
  task automatic write_damping(logic [16:0] v);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; paddr = 3'(REG_DAMPING) << 2; pwdata = 32'(v);
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    damping = v;
  endtask

  // offer one word and wait for acceptance; a typed expectation replaces the predicted one
  task automatic send_word(logic [2:0] s, logic [31:0] t, logic signed [31:0] px,
                           logic signed [31:0] py, logic signed [31:0] pz,
                           bit use_exp = 1'b0, smooth_word_t exp_w = '0);
    smooth_word_t w;
    while (!no_idle && $urandom_range(99) < 22) @(negedge clk);
    in_valid = 1'b1; slot = s; stamp = t;
    pos_x = px; pos_y = py; pos_z = pz;
    w = predict_smooth(s, t, px, py, pz);
    expected_q.push_back(use_exp ? exp_w : w);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  // receiver idling and the long hold-off
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_idle || ($urandom_range(99) >= 22);
    end
  end

  // result check
  always @(posedge clk) begin
    smooth_word_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word x=%0d", out_x);
      end else begin
        e = expected_q.pop_front();
        if (out_x !== e.x || out_y !== e.y || out_z !== e.z || status !== e.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %0d %0d %0d st%0d got %0d %0d %0d st%0d",
                     e.x, e.y, e.z, e.st, out_x, out_y, out_z, status);
        end
      end
    end
  end

  // watchdog on accepted and delivered words
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || psel)
      idle_cnt <= 0;
    else if (expected_q.size() != 0 || !stim_done) begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WD_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  typedef struct {
    logic [2:0] s;
    logic [31:0] t;
    logic signed [31:0] x, y, z;
    bit chk;
    smooth_word_t exp_w;
  } stim_row_t;

  // rows with chk set carry their result; the others go through the predictor
  stim_row_t dir_rows [] = '{
    '{3'd0, 32'd100, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0,
      1'b1, '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, STAT_FIRST}},
    '{3'd0, 32'd100, 32'sd5, 32'sd6, 32'sd7,
      1'b1, '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, STAT_HELD}},
    '{3'd0, 32'd50, 32'sd5, 32'sd6, 32'sd7,
      1'b1, '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, STAT_HELD}},
    '{3'd0, 32'd101, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd65536,
      1'b1, '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd65536, STAT_SMOOTH}},
    '{3'd0, 32'd102, 32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd65536, 1'b0, '0},
    '{3'd1, 32'hFFFF_FFFF, 32'sd1, 32'sd2, 32'sd3,
      1'b1, '{32'sd1, 32'sd2, 32'sd3, STAT_FIRST}},
    '{3'd1, 32'hFFFF_FFFF, 32'sd9, 32'sd9, 32'sd9,
      1'b1, '{32'sd1, 32'sd2, 32'sd3, STAT_HELD}},
    '{3'd2, 32'd0, 32'sd0, 32'sd0, 32'sd0,
      1'b1, '{32'sd0, 32'sd0, 32'sd0, STAT_FIRST}},
    '{3'd2, 32'd1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b0, '0},
    '{3'd2, 32'hFFFF_FFFF, 32'sd0, 32'sd0, 32'sd0, 1'b0, '0},
    '{3'd7, 32'd10, 32'sd1000, -32'sd1000, 32'sd0,
      1'b1, '{32'sd1000, -32'sd1000, 32'sd0, STAT_FIRST}},
    '{3'd7, 32'd20, 32'sd2000, -32'sd2000, 32'sd100, 1'b0, '0}
  };

  initial begin
    logic [2:0] s;
    logic [31:0] t;
    logic [31:0] slot_t [NSLOTS];
    damping = '0;
    for (int i = 0; i < NSLOTS; i++) begin
      hist_valid[i] = 1'b0;
      slot_t[i] = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed rows, first at reset damping then at full damping
    for (int i = 0; i < dir_rows.size(); i++) begin
      if (i == 4) begin
        drain();
        write_damping(17'h10000);
      end
      send_word(dir_rows[i].s, dir_rows[i].t, dir_rows[i].x, dir_rows[i].y, dir_rows[i].z,
                dir_rows[i].chk, dir_rows[i].exp_w);
    end
    drain();

    // long receiver hold-off while words keep coming
    hold_off = 400;
    for (int i = 0; i < 6; i++) send_word(3'(i), 32'd0, 32'sd1, 32'sd2, 32'sd3);
    drain();

    // random phases over damping settings
    for (int p = 0; p < 5; p++) begin
      write_damping(damp_set[p]);
      no_idle = (p == 3);
      for (int i = 0; i < N_RAND / 5; i++) begin
        s = 3'($urandom_range(7));
        if ($urandom_range(99) < 10) t = $urandom;
        else if ($urandom_range(99) < 10) t = slot_t[s] - 32'($urandom_range(3));
        else t = slot_t[s] + 32'($urandom_range(1, ($urandom_range(1) ? 40 : 4000)));
        slot_t[s] = (t > slot_t[s]) ? t : slot_t[s];
        if ($urandom_range(99) < 15)
          send_word(s, t, $urandom, $urandom, $urandom);
        else
          send_word(s, t, $signed(32'($urandom_range(0, 1 << 22))) - (1 << 21),
                    $signed(32'($urandom_range(0, 1 << 22))) - (1 << 21),
                    $signed(32'($urandom_range(0, 1 << 22))) - (1 << 21));
      end
      drain();
    end
    stim_done = 1;
    drain();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

### sim.f
sv/pps_pkg.sv
sv/pps_divider.sv
sv/pps_axis.sv
sv/predictive_position_smoother.sv
sim/tb.sv
